@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion shorthands, sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BOTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bots_pkg.sv @@
// ----------------------------------------------------------------------------
// bots_pkg
// shared constants, codes and controller/datapath types for the tile selector
// ----------------------------------------------------------------------------
package bots_pkg;

  // default sizing
  localparam int MAX_TILES_DEF  = 64;
  localparam int COORD_BITS_DEF = 30;

  // fixed field widths
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NULL_BOX = 2'd1,
    STATUS_NO_TILE  = 2'd2
  } status_e;

  // request type codes
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;
    logic query_start;
    logic issue;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
  } dp_status_t;

endpackage

@@ rtl/bots_item_if.sv @@
// ----------------------------------------------------------------------------
// bots_item_if
// request channel: tile load or element box query, valid/ready handshake
// ----------------------------------------------------------------------------
interface bots_item_if #(
  parameter int COORD_BITS = bots_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bots_pkg::SLOT_W-1:0]   tile_slot;
  logic signed [COORD_BITS-1:0]  box_min_x;
  logic signed [COORD_BITS-1:0]  box_min_y;
  logic signed [COORD_BITS-1:0]  box_max_x;
  logic signed [COORD_BITS-1:0]  box_max_y;

  modport source (
    output valid, req_type, tile_slot, box_min_x, box_min_y, box_max_x, box_max_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, tile_slot, box_min_x, box_min_y, box_max_x, box_max_y,
    output ready
  );
endinterface

@@ rtl/bots_result_if.sv @@
// ----------------------------------------------------------------------------
// bots_result_if
// result channel: chosen tile index and status, valid/ready handshake
// ----------------------------------------------------------------------------
interface bots_result_if;
  logic                          valid;
  logic                          ready;
  logic [bots_pkg::SLOT_W-1:0]   chosen_tile;
  logic [bots_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, chosen_tile, status,
    input  ready
  );

  modport sink (
    input  valid, chosen_tile, status,
    output ready
  );
endinterface

@@ rtl/best_overlap_tile_select_core.sv @@
// ----------------------------------------------------------------------------
// best_overlap_tile_select_core
// tile table plus best-overlap tile lookup for element bounding boxes
// ----------------------------------------------------------------------------
// A load request writes one tile box into the table (slots at or above
// MAX_TILES are dropped); it returns nothing. A query request streams tiles
// 0 .. min(tile_count, MAX_TILES)-1 out of the single tile-table read port,
// one tile per cycle, into a compare / multiply / select pipeline, and keeps
// the request side closed from acceptance until its result is loaded into
// the output register; that load waits while the previous result is still
// held there. A null box or an empty table reads no tiles. The first fully
// containing tile wins; otherwise the intersecting tile with the largest
// overlap area, earliest on ties. The tile table has no reset: query only
// tiles that have been loaded. Write tile_count only while the block is
// idle.
`include "assert_macros.svh"

module best_overlap_tile_select_core #(
  parameter int MAX_TILES  = bots_pkg::MAX_TILES_DEF,
  parameter int COORD_BITS = bots_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bots_pkg::COUNT_W-1:0] cfg_wdata_i,
  bots_item_if.sink                    item_i,
  bots_result_if.source                result_o
);

  bots_pkg::dp_cmd_t    cmd;
  bots_pkg::dp_status_t dp_status;

  // request sequencer
  bots_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_i.valid),
    .in_req_type_i (item_i.req_type),
    .in_ready_o    (item_i.ready),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .status_i      (dp_status),
    .cmd_o         (cmd)
  );

  // table, scan pipeline and result payload
  bots_dp #(
    .MAX_TILES  (MAX_TILES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_tile_slot_i    (item_i.tile_slot),
    .in_box_min_x_i    (item_i.box_min_x),
    .in_box_min_y_i    (item_i.box_min_y),
    .in_box_max_x_i    (item_i.box_max_x),
    .in_box_max_y_i    (item_i.box_max_y),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .out_chosen_tile_o (result_o.chosen_tile),
    .out_status_o      (result_o.status)
  );

  // no new request is taken while tiles are still being read
  `BOTS_ASSERT_IMP(a_issue_blocks_input, cmd.issue, !item_i.ready, "request taken during scan")
  // an accepted query keeps the request side closed in the next cycle
  `BOTS_ASSERT_NXT(a_query_holds_input, cmd.query_start, !item_i.ready, "query did not start scan")
  // a result is only formed after the scan and pipeline have drained
  `BOTS_ASSERT_IMP(a_result_after_drain, cmd.out_load,
                   dp_status.scan_end && !dp_status.pipe_busy, "result before pipeline drain")
  // a new result never overwrites one that is still waiting
  `BOTS_ASSERT_IMP(a_result_no_overwrite, cmd.out_load,
                   !result_o.valid || result_o.ready, "pending result overwritten")

endmodule

@@ rtl/bots_ctrl.sv @@
// ----------------------------------------------------------------------------
// bots_ctrl
// request sequencer: takes loads and queries, drives the tile scan, owns
// the result valid flag
// ----------------------------------------------------------------------------
module bots_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  bots_pkg::dp_status_t status_i,
  output bots_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   is_query;
  logic   out_free;
  logic   finish;

  // handshake qualifiers
  assign in_accept = (state_q == ST_IDLE) && in_valid_i;
  assign is_query  = (in_req_type_i == bots_pkg::REQ_QUERY);
  assign out_free  = !out_valid_q || out_ready_i;
  assign finish    = (state_q == ST_SCAN) && status_i.scan_end && !status_i.pipe_busy
                     && out_free;

  // commands to the datapath
  always_comb begin
    cmd_o.load_wr     = in_accept && !is_query;
    cmd_o.query_start = in_accept && is_query;
    cmd_o.issue       = (state_q == ST_SCAN) && !status_i.scan_end;
    cmd_o.out_load    = finish;
  end

  // next state and result flag
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept && is_query) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/bots_dp.sv @@
// ----------------------------------------------------------------------------
// bots_dp
// tile table memory, query box, four-stage compare / overlap-area pipeline,
// best-tile tracking and result payload register
// ----------------------------------------------------------------------------
module bots_dp #(
  parameter int MAX_TILES  = bots_pkg::MAX_TILES_DEF,
  parameter int COORD_BITS = bots_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bots_pkg::COUNT_W-1:0]      cfg_wdata_i,
  input  logic [bots_pkg::SLOT_W-1:0]       in_tile_slot_i,
  input  logic signed [COORD_BITS-1:0]      in_box_min_x_i,
  input  logic signed [COORD_BITS-1:0]      in_box_min_y_i,
  input  logic signed [COORD_BITS-1:0]      in_box_max_x_i,
  input  logic signed [COORD_BITS-1:0]      in_box_max_y_i,
  input  bots_pkg::dp_cmd_t                 cmd_i,
  output bots_pkg::dp_status_t              status_o,
  output logic [bots_pkg::SLOT_W-1:0]       out_chosen_tile_o,
  output logic [bots_pkg::STATUS_W-1:0]     out_status_o
);

  localparam int IDX_W  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W  = $clog2(MAX_TILES + 1);
  localparam int WORD_W = 4 * COORD_BITS;
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int SLOT_W = bots_pkg::SLOT_W;

  // configuration
  logic [bots_pkg::COUNT_W-1:0] tile_count_q;

  // tile table, word = {hi_y, hi_x, lo_y, lo_x}
  logic [WORD_W-1:0] tile_mem_q [MAX_TILES];
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [IDX_W-1:0]        wr_addr;
  logic                    slot_ok;

  // query context
  logic signed [COORD_BITS-1:0] q_lo_x_q, q_lo_y_q, q_hi_x_q, q_hi_y_q;
  logic                         null_q;
  logic                         null_d;
  logic [CNT_W-1:0]             scan_n_q, scan_n_d;
  logic [CNT_W-1:0]             scan_idx_q;

  // stage 1: table read
  logic              v1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [WORD_W-1:0] rd_word_q;

  // stage 2: compares and overlap extents
  logic signed [COORD_BITS-1:0] t_lo_x, t_lo_y, t_hi_x, t_hi_y;
  logic signed [COORD_BITS-1:0] ov_lo_x, ov_lo_y, ov_hi_x, ov_hi_y;
  logic [COORD_BITS:0]          diff_x, diff_y;
  logic                         t_null, t_contain, t_miss;
  logic                         v2_q, cont2_q, hit2_q;
  logic [IDX_W-1:0]             idx2_q;
  logic [COORD_BITS-1:0]        dx2_q, dy2_q;

  // stage 3: area
  logic              v3_q, cont3_q, hit3_q;
  logic [IDX_W-1:0]  idx3_q;
  logic [AREA_W-1:0] area3_q;

  // best tracking
  logic              found_q, done_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [AREA_W-1:0] best_area_q;
  logic [IDX_W+SLOT_W-1:0] best_ext;

  // result payload
  logic [SLOT_W-1:0]         chosen_q;
  logic [bots_pkg::STATUS_W-1:0] res_status_q;

  // tile count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_count_q <= '0;
    end else if (cfg_we_i) begin
      tile_count_q <= cfg_wdata_i;
    end
  end

  // tile table write and read ports
  assign slot_ext = (IDX_W + SLOT_W)'(in_tile_slot_i);
  assign wr_addr  = slot_ext[IDX_W-1:0];
  assign slot_ok  = (32'(in_tile_slot_i) < MAX_TILES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && slot_ok) begin
      tile_mem_q[wr_addr] <= {in_box_max_y_i, in_box_max_x_i, in_box_min_y_i, in_box_min_x_i};
    end
    if (cmd_i.issue) begin
      rd_word_q <= tile_mem_q[scan_idx_q[IDX_W-1:0]];
      idx1_q    <= scan_idx_q[IDX_W-1:0];
    end
  end

  // scan length: clamp count, nothing to scan for a null box
  assign null_d = (in_box_min_x_i > in_box_max_x_i) || (in_box_min_y_i > in_box_max_y_i);

  always_comb begin
    if (32'(tile_count_q) > MAX_TILES) begin
      scan_n_d = CNT_W'(MAX_TILES);
    end else begin
      scan_n_d = CNT_W'(tile_count_q);
    end
    if (null_d) begin
      scan_n_d = '0;
    end
  end

  // query capture (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      q_lo_x_q <= in_box_min_x_i;
      q_lo_y_q <= in_box_min_y_i;
      q_hi_x_q <= in_box_max_x_i;
      q_hi_y_q <= in_box_max_y_i;
      null_q   <= null_d;
    end
  end

  // scan counter and length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      scan_n_q   <= '0;
    end else if (cmd_i.query_start) begin
      scan_idx_q <= '0;
      scan_n_q   <= scan_n_d;
    end else if (cmd_i.issue) begin
      scan_idx_q <= scan_idx_q + 1'b1;
    end
  end

  // stage 2 combinational: containment, miss and overlap extents
  assign t_lo_x = rd_word_q[COORD_BITS-1:0];
  assign t_lo_y = rd_word_q[2*COORD_BITS-1:COORD_BITS];
  assign t_hi_x = rd_word_q[3*COORD_BITS-1:2*COORD_BITS];
  assign t_hi_y = rd_word_q[4*COORD_BITS-1:3*COORD_BITS];

  assign t_null    = (t_lo_x > t_hi_x) || (t_lo_y > t_hi_y);
  assign t_contain = (q_lo_x_q >= t_lo_x) && (q_hi_x_q <= t_hi_x) &&
                     (q_lo_y_q >= t_lo_y) && (q_hi_y_q <= t_hi_y);
  assign t_miss    = (q_lo_x_q > t_hi_x) || (q_hi_x_q < t_lo_x) ||
                     (q_lo_y_q > t_hi_y) || (q_hi_y_q < t_lo_y);

  assign ov_lo_x = (q_lo_x_q > t_lo_x) ? q_lo_x_q : t_lo_x;
  assign ov_lo_y = (q_lo_y_q > t_lo_y) ? q_lo_y_q : t_lo_y;
  assign ov_hi_x = (q_hi_x_q < t_hi_x) ? q_hi_x_q : t_hi_x;
  assign ov_hi_y = (q_hi_y_q < t_hi_y) ? q_hi_y_q : t_hi_y;

  // extents are non-negative whenever the boxes intersect
  assign diff_x = {ov_hi_x[COORD_BITS-1], ov_hi_x} - {ov_lo_x[COORD_BITS-1], ov_lo_x};
  assign diff_y = {ov_hi_y[COORD_BITS-1], ov_hi_y} - {ov_lo_y[COORD_BITS-1], ov_lo_y};

  // stage 2/3 payload registers
  always_ff @(posedge clk_i) begin
    cont2_q <= !t_null && t_contain;
    hit2_q  <= !t_null && !t_miss;
    idx2_q  <= idx1_q;
    dx2_q   <= diff_x[COORD_BITS-1:0];
    dy2_q   <= diff_y[COORD_BITS-1:0];
    cont3_q <= cont2_q;
    hit3_q  <= hit2_q;
    idx3_q  <= idx2_q;
    area3_q <= AREA_W'(dx2_q) * AREA_W'(dy2_q);
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 4: keep first containing tile, else largest overlap, earlier on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      best_idx_q  <= '0;
      best_area_q <= '0;
    end else if (cmd_i.query_start) begin
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      best_idx_q  <= '0;
      best_area_q <= '0;
    end else if (v3_q && !done_q) begin
      if (cont3_q) begin
        found_q    <= 1'b1;
        done_q     <= 1'b1;
        best_idx_q <= idx3_q;
      end else if (hit3_q && (!found_q || (area3_q > best_area_q))) begin
        found_q     <= 1'b1;
        best_idx_q  <= idx3_q;
        best_area_q <= area3_q;
      end
    end
  end

  // result payload
  assign best_ext = (IDX_W + SLOT_W)'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (found_q) begin
        chosen_q     <= best_ext[SLOT_W-1:0];
        res_status_q <= bots_pkg::STATUS_OK;
      end else begin
        chosen_q     <= '0;
        res_status_q <= null_q ? bots_pkg::STATUS_NULL_BOX : bots_pkg::STATUS_NO_TILE;
      end
    end
  end

  // status to controller and outputs
  assign status_o.scan_end  = (scan_idx_q == scan_n_q);
  assign status_o.pipe_busy = v1_q || v2_q || v3_q;
  assign out_chosen_tile_o  = chosen_q;
  assign out_status_o       = res_status_q;

endmodule
